// ===== rtl/kdlpr_pkg.sv =====
// Shared types and constants for the key debounce, long-press and repeat block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package kdlpr_pkg;

  localparam int NUM_KEYS = 5;

  localparam int FILTER_W = 8;
  localparam int LONG_W   = 16;
  localparam int REPEAT_W = 8;
  localparam int FCNT_W   = FILTER_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_TIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SPEED = 2'd2;

  localparam logic [FILTER_W-1:0] FILTER_TIME_RST  = 8'd5;
  localparam logic [LONG_W-1:0]   LONG_TIME_RST    = 16'd100;
  localparam logic [REPEAT_W-1:0] REPEAT_SPEED_RST = 8'd5;
  localparam logic [FCNT_W-1:0]   FCNT_RST         = 9'd2;

  typedef struct packed {
    logic [FILTER_W-1:0] filter_time;
    logic [LONG_W-1:0]   long_time;
    logic [REPEAT_W-1:0] repeat_speed;
  } cfg_t;

  typedef struct packed {
    logic press;
    logic hold;
  } lane_evt_t;

endpackage

// ===== rtl/key_debounce_long_press_repeat.sv =====
// Top level of the key debounce, long-press and auto-repeat block.
// Depends on kdlpr_pkg and instantiates one kdlpr_lane per key.
`timescale 1ns / 1ps

// Each transfer on the input channel is one tick carrying the raw active-low
// levels of the keys. Every key has its own lane with an integrating debounce
// counter, a pressed flag, a hold counter and a repeat counter; all lanes update
// in parallel in the cycle the tick is accepted, so the block takes one tick per
// clock while the input is not stalled. The lanes' press and hold findings are
// merged into two event vectors and registered, so each tick yields exactly one
// result transfer, even when no event occurred. A two-entry output stage
// (output register plus skid register) lets a tick be accepted while the
// previous result is still waiting; the input is stalled only when both are
// full. Configuration writes should be made while no tick is in flight.
module key_debounce_long_press_repeat (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [kdlpr_pkg::NUM_KEYS-1:0]      in_key_levels,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [kdlpr_pkg::NUM_KEYS-1:0]      out_press_events,
  output logic [kdlpr_pkg::NUM_KEYS-1:0]      out_hold_events,
  input  logic                                cfg_wr_en,
  input  logic [kdlpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kdlpr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import kdlpr_pkg::*;

  cfg_t cfg_r;

  logic in_acc;
  logic out_fire;

  logic [NUM_KEYS-1:0] lane_press;
  logic [NUM_KEYS-1:0] lane_hold;

  logic                out_valid_r;
  logic [NUM_KEYS-1:0] out_press_r;
  logic [NUM_KEYS-1:0] out_hold_r;
  logic                skid_valid_r;
  logic [NUM_KEYS-1:0] skid_press_r;
  logic [NUM_KEYS-1:0] skid_hold_r;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_time  <= FILTER_TIME_RST;
      cfg_r.long_time    <= LONG_TIME_RST;
      cfg_r.repeat_speed <= REPEAT_SPEED_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FILTER_TIME:  cfg_r.filter_time  <= cfg_wdata[FILTER_W-1:0];
        REG_LONG_TIME:    cfg_r.long_time    <= cfg_wdata[LONG_W-1:0];
        REG_REPEAT_SPEED: cfg_r.repeat_speed <= cfg_wdata[REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  // The input is held off only while the skid register is occupied.
  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;

  // One lane per key. A key reads pressed when its level is low.
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    lane_evt_t evt;

    kdlpr_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (in_acc),
      .key_down (!in_key_levels[k]),
      .cfg      (cfg_r),
      .evt      (evt)
    );

    assign lane_press[k] = evt.press;
    assign lane_hold[k]  = evt.hold;
  end

  // Merge stage: the lane findings are gathered into the result vectors and
  // registered. The skid register catches a result when the output is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_fire) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_press_r <= skid_press_r;
        out_hold_r  <= skid_hold_r;
      end else if (in_acc) begin
        out_press_r <= lane_press;
        out_hold_r  <= lane_hold;
      end
    end else if (in_acc) begin
      skid_press_r <= lane_press;
      skid_hold_r  <= lane_hold;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_press_events = out_press_r;
  assign out_hold_events  = out_hold_r;

  // The skid register only ever fills behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output is empty");

  // A tick accepted while the output is full and stalled lands in the skid.
  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("accepted tick lost while output stalled");

  // A released key never raises a press or hold event.
  a_no_event_released: assert property (@(posedge clk) disable iff (!rst_n)
    ((lane_press | lane_hold) & in_key_levels) == '0)
    else $error("event raised by a released key");

  // With nothing buffered or arriving, a delivered result leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !skid_valid_r && !in_acc) |=> !out_valid_r)
    else $error("result repeated after transfer");

endmodule

// ===== rtl/kdlpr_lane.sv =====
// One key lane: debounce integrator, pressed flag, hold and repeat counters.
// Depends on kdlpr_pkg for the configuration and event structs.
`timescale 1ns / 1ps

module kdlpr_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              key_down,
  input  kdlpr_pkg::cfg_t   cfg,
  output kdlpr_pkg::lane_evt_t evt
);
  import kdlpr_pkg::*;

  logic [FCNT_W-1:0]   fcnt_r, fcnt_nxt;
  logic                pressed_r, pressed_nxt;
  logic [LONG_W-1:0]   hold_r, hold_nxt;
  logic [REPEAT_W-1:0] rpt_r, rpt_nxt;

  logic [FCNT_W-1:0]   f_lo;
  logic [FCNT_W-1:0]   f_hi;
  logic [LONG_W-1:0]   hold_inc;
  logic [REPEAT_W-1:0] rpt_inc;

  assign f_lo     = {1'b0, cfg.filter_time};
  assign f_hi     = {cfg.filter_time, 1'b0};
  assign hold_inc = hold_r + 1'b1;
  assign rpt_inc  = rpt_r + 1'b1;

  always_comb begin
    fcnt_nxt    = fcnt_r;
    pressed_nxt = pressed_r;
    hold_nxt    = hold_r;
    rpt_nxt     = rpt_r;
    evt.press   = 1'b0;
    evt.hold    = 1'b0;
    if (key_down) begin
      if (fcnt_r < f_lo) begin
        fcnt_nxt = f_lo;
      end else if (fcnt_r < f_hi) begin
        fcnt_nxt = fcnt_r + 1'b1;
      end else begin
        if (!pressed_r) begin
          pressed_nxt = 1'b1;
          evt.press   = 1'b1;
        end
        if (cfg.long_time != '0) begin
          if (hold_r < cfg.long_time) begin
            hold_nxt = hold_inc;
            evt.hold = (hold_inc == cfg.long_time);
          end else if (cfg.repeat_speed != '0) begin
            if (rpt_inc >= cfg.repeat_speed) begin
              rpt_nxt   = '0;
              evt.press = 1'b1;
            end else begin
              rpt_nxt = rpt_inc;
            end
          end
        end
      end
    end else begin
      if (fcnt_r > f_lo) begin
        fcnt_nxt = f_lo;
      end else if (fcnt_r != '0) begin
        fcnt_nxt = fcnt_r - 1'b1;
      end else begin
        pressed_nxt = 1'b0;
      end
      hold_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r    <= FCNT_RST;
      pressed_r <= 1'b0;
      hold_r    <= '0;
      rpt_r     <= '0;
    end else if (advance) begin
      fcnt_r    <= fcnt_nxt;
      pressed_r <= pressed_nxt;
      hold_r    <= hold_nxt;
      rpt_r     <= rpt_nxt;
    end
  end

endmodule
